FILE: hdl/vmt_pkg.sv
package vmt_pkg;

  localparam int VID_W   = 12;
  localparam int OUT_W   = 6;
  localparam logic [15:0] VID_MAX = 16'd4095;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_PORT_ADD = 3'd2;
  localparam logic [2:0] OP_PORT_DEL = 3'd3;
  localparam logic [2:0] OP_SET_PVID = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] vlan_id;
    logic [2:0]  port_num;
    logic        untagged;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OUT_W-1:0] member_ports;
    logic [OUT_W-1:0] untag_ports;
    logic             entry_valid;
  } out_t;

endpackage

FILE: hdl/vlan_membership_table.sv
// VLAN membership table with an active-VID slot list and per-port default VIDs.
// Input channel in_valid/in_ready carries one request beat (op, VID, port,
// untagged flag); output channel out_valid/out_ready returns one result beat
// per request: status and entry after it, zero on PVID/range/exists/not-found.
// The request and table read are registered at accept; the result register
// is loaded in the execute/write-back state. No new request is taken until
// that state ends, since the input is taken only in idle.
// The slot list is compared in parallel at accept time, first match and first
// free slot are picked in the execute cycle.
// If the result register is still full and out_ready is low, the execute
// cycle holds (no table or slot write) until the result can be loaded.
// Reset: slot 0 holds VID 1, other slots free, default VIDs zero, entry 1
// reads as valid with all ports untagged members until first written.
// Other table entries are undefined until written; no clearing pass.
// The table index is the VID modulo TABLE_DEPTH.
module vlan_membership_table
  import vmt_pkg::*;
#(
  parameter int LIST_SLOTS  = 16,
  parameter int PORT_COUNT  = 6,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = 2 * PORT_COUNT + 1;
  localparam logic [PORT_COUNT-1:0] PORT_MASK = '1;

  localparam int IDX_SH = VID_W + IDX_W;
  localparam longint unsigned IDX_MUL =
    ((64'd1 << IDX_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam bit DEPTH_POW2 = (TABLE_DEPTH == (1 << IDX_W));
  localparam int PROD_W = 2 * VID_W + 2;
  localparam int BACK_W = 2 * VID_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  st_r, st_nxt;
  in_t                   req_r;
  logic [IDX_W-1:0]      idx_r;
  logic [LIST_SLOTS-1:0] match_r, free_r;
  logic                  init_flag_r, init_hit_r;
  logic [ENT_W-1:0]      rd_r;
  logic [VID_W-1:0]      slot_r [LIST_SLOTS];
  logic [VID_W-1:0]      pvid_r [PORT_COUNT];
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  logic [ENT_W-1:0]      mem [TABLE_DEPTH];

  logic                  accept, proceed;
  logic [IDX_W-1:0]      rd_idx, wr_idx;
  logic [LIST_SLOTS-1:0] match_first, free_first, slot_we;
  logic [VID_W-1:0]      slot_wdata;
  logic                  pvid_we, mem_we;
  logic [ENT_W-1:0]      ent_cur, ent_new, ent_show;
  logic [PORT_COUNT-1:0] cur_mem, cur_unt, port_bit;
  logic                  show;
  logic [2:0]            status;

  function automatic logic [OUT_W-1:0] fit_out(input logic [PORT_COUNT-1:0] v);
    logic [PORT_COUNT+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

  // VID mod depth by reciprocal multiplication, exact for any 12-bit VID
  function automatic logic [IDX_W-1:0] tbl_idx(input logic [VID_W-1:0] v);
    logic [PROD_W-1:0] prod;
    logic [VID_W-1:0]  quo;
    logic [BACK_W-1:0] back;
    logic [VID_W-1:0]  rem;
    prod = PROD_W'(v) * PROD_W'(IDX_MUL);
    quo  = VID_W'(prod >> IDX_SH);
    back = BACK_W'(quo) * BACK_W'(TABLE_DEPTH);
    rem  = DEPTH_POW2 ? v : (v - back[VID_W-1:0]);
    return IDX_W'(rem);
  endfunction

  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign proceed  = (st_r == S_EXEC) && (!out_valid_r || out_ready);
  assign rd_idx   = tbl_idx(in_data.vlan_id[VID_W-1:0]);
  assign wr_idx   = idx_r;

  assign match_first = match_r & (~match_r + LIST_SLOTS'(1));
  assign free_first  = free_r & (~free_r + LIST_SLOTS'(1));

  assign ent_cur  = init_hit_r ? {1'b1, PORT_MASK, PORT_MASK} : rd_r;
  assign cur_mem  = ent_cur[PORT_COUNT-1:0];
  assign cur_unt  = ent_cur[2*PORT_COUNT-1:PORT_COUNT];
  assign port_bit = (32'(req_r.port_num) < PORT_COUNT) ?
                    (PORT_COUNT'(1) << req_r.port_num) : '0;

  always_comb begin
    status     = ST_OK;
    show       = 1'b0;
    mem_we     = 1'b0;
    ent_new    = ent_cur;
    slot_we    = '0;
    slot_wdata = req_r.vlan_id[VID_W-1:0];
    pvid_we    = 1'b0;
    if (req_r.op > OP_READ) begin
      status = ST_RANGE;
    end else if (req_r.op != OP_SET_PVID && req_r.vlan_id > VID_MAX) begin
      status = ST_RANGE;
    end else begin
      case (req_r.op)
        OP_CREATE: begin
          if (|match_r) begin
            status = ST_EXISTS;
          end else begin
            slot_we = free_first;
            ent_new = {1'b1, PORT_MASK, {PORT_COUNT{1'b0}}};
            mem_we  = 1'b1;
            show    = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!(|match_r)) begin
            status = ST_NOTFOUND;
          end else begin
            slot_we    = match_first;
            slot_wdata = '0;
            ent_new    = {1'b0, PORT_MASK, {PORT_COUNT{1'b0}}};
            mem_we     = 1'b1;
            show       = 1'b1;
          end
        end
        OP_PORT_ADD, OP_PORT_DEL: begin
          if (!(|match_r)) begin
            status = ST_NOTFOUND;
          end else begin
            show = 1'b1;
            if (!ent_cur[ENT_W-1]) begin
              status = ST_INVALID;
            end else begin
              mem_we = 1'b1;
              if (req_r.op == OP_PORT_ADD) begin
                ent_new = {1'b1,
                           req_r.untagged ? (cur_unt | port_bit) : (cur_unt & ~port_bit),
                           cur_mem | port_bit};
              end else begin
                ent_new = {1'b1, cur_unt & ~port_bit, cur_mem & ~port_bit};
              end
            end
          end
        end
        OP_SET_PVID: begin
          if (!(|match_r)) begin
            status = ST_NOTFOUND;
          end else begin
            pvid_we = (32'(req_r.port_num) < PORT_COUNT);
          end
        end
        OP_READ: begin
          show = 1'b1;
          if (!ent_cur[ENT_W-1]) begin
            status = ST_INVALID;
          end
        end
        default: begin
          status = ST_RANGE;
        end
      endcase
    end
  end

  assign ent_show = show ? (mem_we ? ent_new : ent_cur) : '0;

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      st_nxt = S_EXEC;
    end
    if (proceed) begin
      st_nxt                    = S_IDLE;
      out_valid_nxt             = 1'b1;
      out_data_nxt.status       = status;
      out_data_nxt.member_ports = fit_out(ent_show[PORT_COUNT-1:0]);
      out_data_nxt.untag_ports  = fit_out(ent_show[2*PORT_COUNT-1:PORT_COUNT]);
      out_data_nxt.entry_valid  = ent_show[ENT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      init_flag_r <= 1'b1;
      for (int i = 0; i < LIST_SLOTS; i++) begin
        slot_r[i] <= (i == 0) ? VID_W'(1) : '0;
      end
      for (int p = 0; p < PORT_COUNT; p++) begin
        pvid_r[p] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (proceed && mem_we && wr_idx == IDX_W'(1)) begin
        init_flag_r <= 1'b0;
      end
      if (proceed) begin
        for (int i = 0; i < LIST_SLOTS; i++) begin
          if (slot_we[i]) begin
            slot_r[i] <= slot_wdata;
          end
        end
        for (int p = 0; p < PORT_COUNT; p++) begin
          if (pvid_we && 32'(req_r.port_num) == p) begin
            pvid_r[p] <= req_r.vlan_id[VID_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      req_r      <= in_data;
      idx_r      <= rd_idx;
      init_hit_r <= init_flag_r && (rd_idx == IDX_W'(1));
      for (int i = 0; i < LIST_SLOTS; i++) begin
        match_r[i] <= (16'(slot_r[i]) == in_data.vlan_id);
        free_r[i]  <= (slot_r[i] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && mem_we) begin
      mem[wr_idx] <= ent_new;
    end
    if (accept) begin
      rd_r <= mem[rd_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r == S_EXEC))
    else $error("request not moved to execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_EXEC))
    else $error("result loaded outside execute");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(slot_we))
    else $error("more than one slot written");

  a_hold_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_EXEC) && out_valid_r && !out_ready) |=> (st_r == S_EXEC))
    else $error("execute left while result stalled");

endmodule
